>>> hw/rtl/lgs_pkg.sv
// ============================================================================
// lgs_pkg: shared types and constants for the life generation step core
// Operation codes, controller states and the command bundle that the
// controller sends to the datapath.
// ============================================================================
package lgs_pkg;

    // Operation codes on the func port
    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_STEP  = 2'd1,
        FUNC_DUMP  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } ctrl_state_t;

    // Lag from issuing a row read to emitting the row that it completes:
    // the registered read, then the window shift, then the arrival of the
    // row below.
    localparam int EMIT_LAG = 3;

    // Per-cycle commands from controller to datapath
    typedef struct packed {
        logic load;    // write the input row into the grid
        logic rd_en;   // read the grid row at rd_addr
        logic shift;   // shift the three-row window
        logic emit;    // register one result row
        logic adv;     // emitted row is the next generation, written back
    } lgs_cmd_t;

endpackage

>>> hw/rtl/lgs_ctrl.sv
// ============================================================================
// lgs_ctrl: operation sequencer
// Decodes each accepted item and walks the grid rows for a step or a dump,
// driving the datapath with read, shift, emit and write-back commands.
// ============================================================================
module lgs_ctrl
    import lgs_pkg::*;
#(
    parameter int ROWS = 20
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [1:0]               func,
    output logic                     busy,
    output lgs_cmd_t                 cmd,
    output logic [$clog2(ROWS)-1:0]  rd_addr,
    output logic [$clog2(ROWS)-1:0]  emit_row
);

    localparam int ADDR_W = $clog2(ROWS);
    localparam int CNT_W  = $clog2(ROWS + EMIT_LAG);
    localparam logic [CNT_W-1:0] CNT_ROWS = CNT_W'(ROWS);
    localparam logic [CNT_W-1:0] CNT_LAG  = CNT_W'(EMIT_LAG);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROWS + EMIT_LAG - 1);

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             adv_reg, adv_next;
    logic [CNT_W-1:0] emit_cnt;

    // State, walk counter and operation flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            adv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            adv_reg   <= adv_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        adv_next   = adv_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (func_t'(func))
                        FUNC_WRITE: cmd.load = 1'b1;
                        FUNC_STEP:
                        begin
                            state_next = ST_RUN;
                            cnt_next   = '0;
                            adv_next   = 1'b1;
                        end
                        FUNC_DUMP:
                        begin
                            state_next = ST_RUN;
                            cnt_next   = '0;
                            adv_next   = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                cmd.rd_en = (cnt_reg < CNT_ROWS);
                cmd.shift = 1'b1;
                cmd.emit  = (cnt_reg >= CNT_LAG);
                cmd.adv   = adv_reg;
                if (cnt_reg == CNT_LAST)
                    state_next = ST_IDLE;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Row addresses: read leads emit by the window lag
    assign emit_cnt = cnt_reg - CNT_LAG;
    assign rd_addr  = cnt_reg[ADDR_W-1:0];
    assign emit_row = emit_cnt[ADDR_W-1:0];
    assign busy     = (state_reg == ST_RUN);

    // Checks
    a_emit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> busy)
        else $error("row emitted outside a walk");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!busy && !cmd.rd_en && !cmd.emit))
        else $error("row write overlaps a walk");

    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && cnt_reg == CNT_LAST) |=> !busy)
        else $error("walk did not end after the last row");

    a_walk_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == FUNC_STEP || func == FUNC_DUMP)) |=>
        (busy && cnt_reg == '0))
        else $error("accepted step or dump did not start a walk");

endmodule

>>> hw/rtl/lgs_datapath.sv
// ============================================================================
// lgs_datapath: grid storage and row rule
// Holds the grid in a one-write one-read memory, slides a three-row window
// over it and computes one full row of the next generation per cycle.
// ============================================================================
module lgs_datapath
    import lgs_pkg::*;
#(
    parameter int ROWS = 20,
    parameter int COLS = 40
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lgs_cmd_t                 cmd,
    input  logic [$clog2(ROWS)-1:0]  rd_addr,
    input  logic [$clog2(ROWS)-1:0]  emit_row,
    input  logic [$clog2(ROWS)-1:0]  row_index,
    input  logic [COLS-1:0]          row_cells,
    output logic                     out_valid,
    output logic [$clog2(ROWS)-1:0]  out_row_index,
    output logic [COLS-1:0]          out_row_cells,
    output logic                     last_row
);

    localparam int ADDR_W = $clog2(ROWS);
    localparam logic [ADDR_W:0]   IDX_ROWS = (ADDR_W + 1)'(ROWS);
    localparam logic [ADDR_W-1:0] IDX_LAST = ADDR_W'(ROWS - 1);

    logic [COLS-1:0]   grid_mem [ROWS];
    logic [ROWS-1:0]   valid_reg, valid_next;
    logic [COLS-1:0]   rd_q_reg;
    logic              rd_ok_reg, rd_ok_next;
    logic [COLS-1:0]   rd_row;
    logic [COLS-1:0]   prev_reg, cur_reg, nxt_reg;
    logic [COLS-1:0]   new_row;
    logic              idx_ok;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [COLS-1:0]   wr_data;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_row_index_reg;
    logic [COLS-1:0]   out_row_cells_reg;
    logic              last_row_reg;

    // Write port: input row load or generation write-back
    assign idx_ok  = ({1'b0, row_index} < IDX_ROWS);
    assign wr_en   = (cmd.load && idx_ok) || (cmd.emit && cmd.adv);
    assign wr_addr = cmd.load ? row_index : emit_row;
    assign wr_data = cmd.load ? row_cells : new_row;

    // Grid memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            grid_mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_q_reg <= grid_mem[rd_addr];
    end

    // Row valid bits: an unwritten row reads as all dead
    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
            valid_next[wr_addr] = 1'b1;
    end
    assign rd_ok_next = cmd.rd_en && valid_reg[rd_addr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    // No read or invalid row shifts in a dead row (also the edge rows)
    assign rd_row = rd_ok_reg ? rd_q_reg : '0;

    // Three-row window of the previous generation
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= nxt_reg;
            nxt_reg  <= rd_row;
        end
    end

    // B3/S23 rule on every column of the middle row, dead border outside
    always_comb
    begin : life_rule
        logic [COLS+1:0] up_ext;
        logic [COLS+1:0] mid_ext;
        logic [COLS+1:0] dn_ext;
        logic [3:0]      n;
        up_ext  = {1'b0, prev_reg, 1'b0};
        mid_ext = {1'b0, cur_reg, 1'b0};
        dn_ext  = {1'b0, nxt_reg, 1'b0};
        new_row = '0;
        for (int j = 0; j < COLS; j++)
        begin
            n = 4'(up_ext[j]) + 4'(up_ext[j+1]) + 4'(up_ext[j+2])
              + 4'(mid_ext[j]) + 4'(mid_ext[j+2])
              + 4'(dn_ext[j]) + 4'(dn_ext[j+1]) + 4'(dn_ext[j+2]);
            new_row[j] = (n == 4'd3) || (cur_reg[j] && (n == 4'd2));
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= cmd.emit;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_row_index_reg <= emit_row;
            out_row_cells_reg <= cmd.adv ? new_row : cur_reg;
            last_row_reg      <= (emit_row == IDX_LAST);
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_row_index = out_row_index_reg;
    assign out_row_cells = out_row_cells_reg;
    assign last_row      = last_row_reg;

endmodule

>>> hw/rtl/life_generation_step_core.sv
// ============================================================================
// life_generation_step_core: Game of Life (B3/S23) generation engine
// Keeps a ROWS x COLS grid with a dead border; loads rows, advances one
// generation and dumps the grid one row per cycle.
// ============================================================================
// Usage:
//   An item is taken at a clock edge with start high and busy low.
//   func write row: row_cells goes into row row_index in that same edge;
//     an index at or above ROWS is dropped. No result, busy stays low, so
//     a new item can follow in the next cycle.
//   func step / dump: busy rises for the walk. Row 0 shows on the
//     result ports once the row window has filled, then one row per
//     cycle, out_valid high for each, last_row high on row ROWS-1.
//     Step writes each new row back as it is emitted; the next item is
//     taken only after the walk has ended and busy has fallen.
//   The walk is bound by the single read port of the grid memory: one
//   row read per cycle, plus filling the row window; the next item is
//   taken in the idle state after the walk.
//   Code 3 is ignored.
//   Results are strobes: the receiver must take them when shown, there
//   is no back-pressure.
//   Reset: the grid reads as all dead (per-row valid bits), no walk runs.
// ============================================================================
module life_generation_step_core
    import lgs_pkg::*;
#(
    parameter int ROWS = 20,
    parameter int COLS = 40
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               func,
    input  logic [$clog2(ROWS)-1:0]  row_index,
    input  logic [COLS-1:0]          row_cells,
    output logic                     out_valid,
    output logic [$clog2(ROWS)-1:0]  out_row_index,
    output logic [COLS-1:0]          out_row_cells,
    output logic                     last_row
);

    localparam int ADDR_W = $clog2(ROWS);

    lgs_cmd_t          cmd;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] emit_row;

    // Sequencer
    lgs_ctrl #(
        .ROWS (ROWS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .func     (func),
        .busy     (busy),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .emit_row (emit_row)
    );

    // Grid storage and rule
    lgs_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .emit_row      (emit_row),
        .row_index     (row_index),
        .row_cells     (row_cells),
        .out_valid     (out_valid),
        .out_row_index (out_row_index),
        .out_row_cells (out_row_cells),
        .last_row      (last_row)
    );

endmodule

>>> bench/tb_life_generation_step_core.sv
// ============================================================================
// tb_life_generation_step_core: self-checking bench for the life step core
// Sends row writes, generation steps, dumps and unused codes through the
// start/busy handshake. A grid model predicts every dumped row, and each
// strobed result row is checked in order against it.
// ============================================================================
module tb_life_generation_step_core
    import lgs_pkg::*;
();

    localparam int ROWS       = 20;
    localparam int COLS       = 40;
    localparam int IDX_W      = $clog2(ROWS);
    localparam int IDX_MAX    = (1 << IDX_W) - 1;
    localparam int CLK_PERIOD = 10;
    localparam int DRAIN_MAX  = 50 * ROWS;

    // One dumped row as the block should present it
    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [COLS-1:0]  cells;
        logic             last;
    } grid_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       func;
    logic [IDX_W-1:0] row_index;
    logic [COLS-1:0]  row_cells;
    logic             out_valid;
    logic [IDX_W-1:0] out_row_index;
    logic [COLS-1:0]  out_row_cells;
    logic             last_row;

    // Grid model and the rows it still owes
    logic [COLS-1:0] grid_model [ROWS];
    grid_row_t       pending_rows [$];

    int errors;
    int rows_checked;
    int n_writes;
    int n_steps;
    int n_dumps;
    int n_ignored;
    bit idle_enable;

    life_generation_step_core #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .row_index     (row_index),
        .row_cells     (row_cells),
        .out_valid     (out_valid),
        .out_row_index (out_row_index),
        .out_row_cells (out_row_cells),
        .last_row      (last_row)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin
        #(CLK_PERIOD * 200000);
        $display("[life_generation_step_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Grid model
    // ------------------------------------------------------------------------

    // B3/S23 on a dead border, every cell from the old generation
    function automatic void advance_grid_model();
        logic [COLS-1:0] next_rows [ROWS];
        int              nbrs;
        int              rr;
        int              cc;
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                nbrs = 0;
                for (int dr = -1; dr <= 1; dr++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && rr < ROWS &&
                            cc >= 0 && cc < COLS)
                            nbrs += grid_model[rr][cc];
                    end
                end
                next_rows[r][c] = (nbrs == 3) || (grid_model[r][c] && nbrs == 2);
            end
        end
        for (int r = 0; r < ROWS; r++)
            grid_model[r] = next_rows[r];
    endfunction

    // Owe one full dump of the current grid
    function automatic void queue_grid_dump();
        grid_row_t row;
        for (int r = 0; r < ROWS; r++)
        begin
            row.idx   = IDX_W'(r);
            row.cells = grid_model[r];
            row.last  = (r == ROWS - 1);
            pending_rows.push_back(row);
        end
    endfunction

    // Apply one accepted item to the model
    function automatic void predict_command(func_t f, logic [IDX_W-1:0] idx,
                                            logic [COLS-1:0] cells);
        case (f)
            FUNC_WRITE:
            begin
                // out-of-range rows are dropped
                if (idx < ROWS)
                    grid_model[idx] = cells;
                n_writes++;
            end
            FUNC_STEP:
            begin
                advance_grid_model();
                queue_grid_dump();
                n_steps++;
            end
            FUNC_DUMP:
            begin
                queue_grid_dump();
                n_dumps++;
            end
            default:
                n_ignored++;
        endcase
    endfunction

    // Random row with a varying density so patterns survive a few steps
    function automatic logic [COLS-1:0] random_row();
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] m;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        m = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       return a[COLS-1:0] & b[COLS-1:0];
            1, 2:    return a[COLS-1:0];
            3:       return a[COLS-1:0] | b[COLS-1:0];
            4:       return a[COLS-1:0] & b[COLS-1:0] & m[COLS-1:0];
            default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Item driver: start stays high into the next item unless a gap is taken
    // ------------------------------------------------------------------------
    task automatic issue_command(func_t f, logic [IDX_W-1:0] idx,
                                 logic [COLS-1:0] cells);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        start     <= 1'b1;
        func      <= f;
        row_index <= idx;
        row_cells <= cells;
        do
            @(posedge clk);
        while (busy);
        predict_command(f, idx, cells);
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every strobe must match the oldest owed row
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : row_check
        grid_row_t want;
        if (rst_n && out_valid)
        begin
            if (pending_rows.size() == 0)
            begin
                $error("unexpected result row: out_row_index=%0d out_row_cells=%h",
                       out_row_index, out_row_cells);
                errors++;
            end
            else
            begin
                want = pending_rows.pop_front();
                if (out_row_index !== want.idx)
                begin
                    $error("out_row_index: expected %0d, got %0d", want.idx, out_row_index);
                    errors++;
                end
                if (out_row_cells !== want.cells)
                begin
                    $error("out_row_cells: expected %h, got %h", want.cells, out_row_cells);
                    errors++;
                end
                if (last_row !== want.last)
                begin
                    $error("last_row: expected %0d, got %0d", want.last, last_row);
                    errors++;
                end
                rows_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Fresh grid dumps as all dead; code 3 does nothing
    task automatic test_empty_grid();
        issue_command(FUNC_DUMP, '0, '0);
        issue_command(FUNC_NONE, '1, '1);
    endtask

    // Row writes at the index and column extremes, out-of-range indexes
    task automatic test_row_writes();
        issue_command(FUNC_WRITE, IDX_W'(0), '1);
        issue_command(FUNC_WRITE, IDX_W'(ROWS - 1), '1);
        issue_command(FUNC_WRITE, IDX_W'(5), {1'b1, {(COLS - 2){1'b0}}, 1'b1});
        issue_command(FUNC_WRITE, IDX_W'(9), 40'h55_AAAA_5555);
        issue_command(FUNC_WRITE, IDX_W'(ROWS), '1);
        issue_command(FUNC_WRITE, IDX_W'(IDX_MAX), '1);
        issue_command(FUNC_NONE, IDX_W'(3), 40'hFF_0000_FFFF);
        issue_command(FUNC_DUMP, IDX_W'(IDX_MAX), '1);
    endtask

    // Full border rows, then a corner block and an edge blinker
    task automatic test_edge_patterns();
        issue_command(FUNC_STEP, '0, '0);
        issue_command(FUNC_WRITE, IDX_W'(0), 40'h3);
        issue_command(FUNC_WRITE, IDX_W'(1), 40'h3);
        issue_command(FUNC_WRITE, IDX_W'(2), '0);
        issue_command(FUNC_WRITE, IDX_W'(ROWS - 3), '0);
        issue_command(FUNC_WRITE, IDX_W'(ROWS - 2), 40'h7 << (COLS - 3));
        issue_command(FUNC_WRITE, IDX_W'(ROWS - 1), '0);
        issue_command(FUNC_STEP, IDX_W'(7), '1);
        issue_command(FUNC_STEP, '1, '0);
    endtask

    // Mostly row writes and steps with random content, some noise
    task automatic test_random_traffic(int n_items);
        int               pick;
        logic [IDX_W-1:0] idx;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                if ($urandom_range(0, 9) == 0)
                    idx = IDX_W'($urandom_range(ROWS, IDX_MAX));
                else
                    idx = IDX_W'($urandom_range(0, ROWS - 1));
                issue_command(FUNC_WRITE, idx, random_row());
            end
            else if (pick < 85)
                issue_command(FUNC_STEP, IDX_W'($urandom), random_row());
            else if (pick < 95)
                issue_command(FUNC_DUMP, IDX_W'($urandom), random_row());
            else
                issue_command(FUNC_NONE, IDX_W'($urandom), random_row());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int guard;
        rst_n        = 1'b0;
        start        = 1'b0;
        func         = FUNC_WRITE;
        row_index    = '0;
        row_cells    = '0;
        errors       = 0;
        rows_checked = 0;
        n_writes     = 0;
        n_steps      = 0;
        n_dumps      = 0;
        n_ignored    = 0;
        idle_enable  = 1'b1;
        for (int r = 0; r < ROWS; r++)
            grid_model[r] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_grid();
        test_row_writes();
        test_edge_patterns();
        test_random_traffic(400);
        // back-to-back tail
        idle_enable = 1'b0;
        test_random_traffic(100);
        start <= 1'b0;

        // wait for owed rows, then let the pipeline settle
        guard = 0;
        while (pending_rows.size() != 0 && guard < DRAIN_MAX)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (ROWS + EMIT_LAG + 4) @(posedge clk);

        $display("Run covered %0d row writes, %0d steps, %0d dumps and %0d unused codes.",
                 n_writes, n_steps, n_dumps, n_ignored);
        $display("%0d result rows checked, %0d mismatches, %0d rows still owed.",
                 rows_checked, errors, pending_rows.size());
        if (errors == 0 && pending_rows.size() == 0)
            $display("[life_generation_step_core] OK");
        else
            $display("[life_generation_step_core] ERROR");
        $finish;
    end

endmodule
